>>> rtl/hlc_pkg.sv
// Shared widths, codes, word types and mask helper for the hybrid logical clock.
package hlc_pkg;

   // Field widths
   localparam int unsigned STAMP_W = 64;
   localparam int unsigned NS_W    = 60;
   localparam int unsigned CSR_W   = 63;

   // Nanoseconds to clock units: multiply by 16
   localparam int unsigned NS_SHIFT = 4;

   // Default split between physical and logical bits
   localparam int unsigned LOGICAL_BITS_DEF = 18;

   // Allowed skew after reset, in clock units
   localparam logic [STAMP_W-1:0] OFFSET_RESET = 64'd16000000000;

   // Request kinds
   localparam logic KIND_LOCAL = 1'b0;
   localparam logic KIND_RECV  = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [NS_W-1:0]    local_ns;
      logic [STAMP_W-1:0] msg_stamp;
   } req_word_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [STAMP_W-1:0] offset;
      logic               sync_error;
   } mid_word_type;

   // Mask with the low 'bits' logical bits set
   function automatic logic [STAMP_W-1:0] logical_mask(input int unsigned bits);
      logical_mask = ~({STAMP_W{1'b1}} << bits);
   endfunction

endpackage

>>> rtl/hlc_if.sv
// Valid/ready channel interfaces for request and response words.
interface hlc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [hlc_pkg::NS_W-1:0]     local_ns;
   logic [hlc_pkg::STAMP_W-1:0]  msg_stamp;

   modport source (output valid, kind, local_ns, msg_stamp, input ready);
   modport sink   (input valid, kind, local_ns, msg_stamp, output ready);
endinterface

interface hlc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hlc_pkg::STAMP_W-1:0]  stamp;
   logic [hlc_pkg::STAMP_W-1:0]  offset;
   logic                         sync_error;
   logic [hlc_pkg::STAMP_W-1:0]  upper_bound;

   modport source (output valid, stamp, offset, sync_error, upper_bound, input ready);
   modport sink   (input valid, stamp, offset, sync_error, upper_bound, output ready);
endinterface

>>> rtl/hlc_merge.sv
// Clock state register and combinational HLC merge of local time and message stamp, with a registered result.
module hlc_merge #(
   parameter int unsigned LOGICAL_BITS = hlc_pkg::LOGICAL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  hlc_pkg::req_word_type        in_word,
   input  logic [hlc_pkg::STAMP_W-1:0]  max_offset,
   output logic                         out_valid,
   input  logic                         out_ready,
   output hlc_pkg::mid_word_type        out_word
);

   localparam logic [hlc_pkg::STAMP_W-1:0] LMASK = hlc_pkg::logical_mask(LOGICAL_BITS);
   localparam logic [hlc_pkg::STAMP_W-1:0] PMASK = ~LMASK;

   logic [hlc_pkg::STAMP_W-1:0] clock_value_ff, clock_value_in;
   logic                        valid_ff, valid_in;
   hlc_pkg::mid_word_type       word_ff, word_in;

   logic [hlc_pkg::STAMP_W-1:0] pt, hp, ml, clk_inc, msg_inc, merged;
   logic [hlc_pkg::STAMP_W:0]   pt_limit;
   logic                        is_recv, too_far, take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // Physical parts of local time, stored clock and message
   assign pt      = {in_word.local_ns, {hlc_pkg::NS_SHIFT{1'b0}}} & PMASK;
   assign hp      = clock_value_ff & PMASK;
   assign ml      = in_word.msg_stamp & PMASK;
   assign clk_inc = clock_value_ff + hlc_pkg::STAMP_W'(1);
   assign msg_inc = in_word.msg_stamp + hlc_pkg::STAMP_W'(1);
   assign is_recv = (in_word.kind == hlc_pkg::KIND_RECV);

   // Message lead over local time exceeds skew when ml > pt + max_offset
   assign pt_limit = {1'b0, pt} + {1'b0, max_offset};
   assign too_far  = is_recv && ({1'b0, ml} > pt_limit);

   // Select the new clock value
   always_comb begin
      if (!is_recv) begin
         merged = (hp < pt) ? pt : clk_inc;
      end else begin
         priority if (hp < ml) begin
            merged = (ml < pt) ? pt : msg_inc;
         end else if (hp < pt) begin
            merged = pt;
         end else if (pt <= ml) begin
            merged = (clock_value_ff < in_word.msg_stamp) ? msg_inc : clk_inc;
         end else begin
            merged = clk_inc;
         end
      end
   end

   // Build the next result word
   always_comb begin
      word_in            = word_ff;
      valid_in           = valid_ff;
      clock_value_in     = clock_value_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (take) begin
         word_in.stamp      = too_far ? '0 : merged;
         word_in.offset     = (is_recv && (ml > pt)) ? (ml - pt) : '0;
         word_in.sync_error = too_far;
         if (!too_far) begin
            clock_value_in = merged;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_value_ff <= '0;
         valid_ff       <= 1'b0;
      end else begin
         clock_value_ff <= clock_value_in;
         valid_ff       <= valid_in;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> rtl/hlc_bound.sv
// Output register stage: adds the skew bound and holds the response word.
module hlc_bound #(
   parameter int unsigned LOGICAL_BITS = hlc_pkg::LOGICAL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  hlc_pkg::mid_word_type        in_word,
   input  logic [hlc_pkg::STAMP_W-1:0]  max_offset,
   hlc_rsp_if.source                    rsp_chan
);

   localparam logic [hlc_pkg::STAMP_W-1:0] LMASK = hlc_pkg::logical_mask(LOGICAL_BITS);

   logic                        valid_ff;
   hlc_pkg::mid_word_type       word_ff;
   logic [hlc_pkg::STAMP_W-1:0] upper_ff, upper_in;

   assign in_ready = !valid_ff || rsp_chan.ready;

   // Upper bound wraps modulo 2^64
   assign upper_in = (in_word.stamp + max_offset) | LMASK;

   // Hold the word until taken, load the next one behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         word_ff  <= in_word;
         upper_ff <= upper_in;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.stamp       = word_ff.stamp;
   assign rsp_chan.offset      = word_ff.offset;
   assign rsp_chan.sync_error  = word_ff.sync_error;
   assign rsp_chan.upper_bound = upper_ff;

endmodule

>>> rtl/hybrid_logical_clock_core.sv
// Hybrid logical clock core: timestamp requests in, stamped response words out.
// A word accepted on req passes the input register, the merge register and the output register to rsp.
// Throughput: one word per cycle while rsp is not stalled; the clock state updates through
// the merge compare/select loop, the skew bound add sits in the output stage.
// Reset (synchronous, active high) clears the clock state and all valid flags
// and sets max_offset to 16000000000 clock units.
module hybrid_logical_clock_core #(
   parameter int unsigned LOGICAL_BITS = hlc_pkg::LOGICAL_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   hlc_req_if.sink                     req_chan,
   hlc_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  logic [hlc_pkg::CSR_W-1:0]   csr_wdata
);

   localparam logic [hlc_pkg::STAMP_W-1:0] LMASK = hlc_pkg::logical_mask(LOGICAL_BITS);

   logic [hlc_pkg::STAMP_W-1:0] max_offset_ff, max_offset_in;
   logic                        s1_valid_ff;
   hlc_pkg::req_word_type       s1_word_ff;
   logic                        s2_ready, s2_valid, s3_ready;
   hlc_pkg::mid_word_type       s2_word;

   // Round the written skew up to a whole physical step
   assign max_offset_in = ({1'b0, csr_wdata} + LMASK) & ~LMASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_offset_ff <= hlc_pkg::OFFSET_RESET;
      end else if (csr_we) begin
         max_offset_ff <= max_offset_in;
      end
   end

   // Input register
   assign req_chan.ready = !s1_valid_ff || s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         s1_word_ff.kind      <= req_chan.kind;
         s1_word_ff.local_ns  <= req_chan.local_ns;
         s1_word_ff.msg_stamp <= req_chan.msg_stamp;
      end
   end

   hlc_merge #(
      .LOGICAL_BITS (LOGICAL_BITS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid_ff),
      .in_ready   (s2_ready),
      .in_word    (s1_word_ff),
      .max_offset (max_offset_ff),
      .out_valid  (s2_valid),
      .out_ready  (s3_ready),
      .out_word   (s2_word)
   );

   hlc_bound #(
      .LOGICAL_BITS (LOGICAL_BITS)
   ) u_bound (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid),
      .in_ready   (s3_ready),
      .in_word    (s2_word),
      .max_offset (max_offset_ff),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> rtl/hlc_checker.sv
// Port-level checker for the hybrid logical clock core, with its bind.
module hlc_checker #(
   parameter int unsigned LOGICAL_BITS = hlc_pkg::LOGICAL_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [hlc_pkg::STAMP_W-1:0]  rsp_stamp,
   input logic [hlc_pkg::STAMP_W-1:0]  rsp_offset,
   input logic                         rsp_sync_error,
   input logic [hlc_pkg::STAMP_W-1:0]  rsp_upper_bound
);

   localparam logic [hlc_pkg::STAMP_W-1:0] LMASK = hlc_pkg::logical_mask(LOGICAL_BITS);

   // Rejected message gives a zero stamp and a nonzero lead
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sync_error |-> (rsp_stamp == '0) && (rsp_offset != '0))
      else $error("sync error word has nonzero stamp or zero offset");

   // Upper bound always has all logical bits set
   a_bound_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_upper_bound & LMASK) == LMASK))
      else $error("upper bound logical bits not all set");

   // No response word right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // Stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stamp)
         && $stable(rsp_upper_bound))
      else $error("stalled response word changed");

endmodule

bind hybrid_logical_clock_core hlc_checker #(
   .LOGICAL_BITS (LOGICAL_BITS)
) u_hlc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_stamp       (rsp_chan.stamp),
   .rsp_offset      (rsp_chan.offset),
   .rsp_sync_error  (rsp_chan.sync_error),
   .rsp_upper_bound (rsp_chan.upper_bound)
);

>>> tb/hlc_stamp_checker.sv
// Response predictor and scoreboard for the hybrid logical clock core.
module hlc_stamp_checker #(
   parameter int unsigned LOGICAL_BITS = hlc_pkg::LOGICAL_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_kind,
   input  logic [hlc_pkg::NS_W-1:0]      req_local_ns,
   input  logic [hlc_pkg::STAMP_W-1:0]   req_msg_stamp,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [hlc_pkg::STAMP_W-1:0]   rsp_stamp,
   input  logic [hlc_pkg::STAMP_W-1:0]   rsp_offset,
   input  logic                          rsp_sync_error,
   input  logic [hlc_pkg::STAMP_W-1:0]   rsp_upper_bound,
   input  logic                          csr_we,
   input  logic [hlc_pkg::CSR_W-1:0]     csr_wdata,
   output int unsigned                   fail_count,
   output int unsigned                   pending_count
);
   import hlc_pkg::*;

   localparam logic [STAMP_W-1:0] LOGIC_MASK = (64'd1 << LOGICAL_BITS) - 64'd1;
   localparam logic [STAMP_W-1:0] PHYS_MASK  = ~LOGIC_MASK;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [STAMP_W-1:0] offset;
      logic               sync_error;
      logic [STAMP_W-1:0] upper_bound;
   } stamp_result_type;

   stamp_result_type   pending_words[$];
   logic [STAMP_W-1:0] clock_state;
   logic [STAMP_W-1:0] skew_limit;
   int unsigned        mismatches;

   // Advance the hybrid clock by one request word and form its response word
   function automatic stamp_result_type hlc_advance(
      input  logic               kind,
      input  logic [NS_W-1:0]    ns,
      input  logic [STAMP_W-1:0] msg,
      input  logic [STAMP_W-1:0] held,
      input  logic [STAMP_W-1:0] skew,
      output logic [STAMP_W-1:0] held_next
   );
      logic [STAMP_W-1:0] pt;
      logic [STAMP_W-1:0] hp;
      logic [STAMP_W-1:0] ml;
      stamp_result_type   r;
      pt = {ns, {NS_SHIFT{1'b0}}} & PHYS_MASK;
      hp = held & PHYS_MASK;
      ml = msg & PHYS_MASK;
      r = '0;
      held_next = held;
      if (kind == KIND_LOCAL) begin
         r.stamp = (hp < pt) ? pt : held + 64'd1;
         held_next = r.stamp;
      end else begin
         r.offset = (ml > pt) ? ml - pt : '0;
         if (r.offset > skew) begin
            // too far ahead: flag it, leave the clock alone
            r.sync_error = 1'b1;
         end else begin
            // four-way merge of held clock, physical time and message
            if (hp < ml) begin
               r.stamp = (ml < pt) ? pt : msg + 64'd1;
            end else if (hp < pt) begin
               r.stamp = pt;
            end else if (pt <= ml) begin
               r.stamp = ((held < msg) ? msg : held) + 64'd1;
            end else begin
               r.stamp = held + 64'd1;
            end
            held_next = r.stamp;
         end
      end
      r.upper_bound = (r.stamp + skew) | LOGIC_MASK;
      return r;
   endfunction

   always @(posedge clock) begin : watch_words
      stamp_result_type   want;
      stamp_result_type   got;
      logic [STAMP_W-1:0] next_state;
      if (reset) begin
         clock_state = '0;
         skew_limit  = OFFSET_RESET;
         mismatches  = 0;
         pending_words.delete();
      end else begin
         // compare the response word with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_stamp, rsp_offset, rsp_sync_error, rsp_upper_bound};
            if (pending_words.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("unexpected response word: stamp %h offset %h err %b bound %h",
                           got.stamp, got.offset, got.sync_error, got.upper_bound);
               end
            end else begin
               want = pending_words.pop_front();
               if (got.stamp !== want.stamp || got.offset !== want.offset ||
                   got.sync_error !== want.sync_error ||
                   got.upper_bound !== want.upper_bound) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("response mismatch at %0t:", $realtime);
                     $display("  expected stamp %h offset %h err %b bound %h",
                              want.stamp, want.offset, want.sync_error, want.upper_bound);
                     $display("  actual   stamp %h offset %h err %b bound %h",
                              got.stamp, got.offset, got.sync_error, got.upper_bound);
                  end
               end
            end
         end
         // predict the response for the accepted request word
         if (req_valid && req_ready) begin
            want = hlc_advance(req_kind, req_local_ns, req_msg_stamp, clock_state,
                               skew_limit, next_state);
            pending_words.push_back(want);
            clock_state = next_state;
         end
         // hold the skew limit rounded up to whole physical units
         if (csr_we) begin
            skew_limit = ({1'b0, csr_wdata} + LOGIC_MASK) & PHYS_MASK;
         end
      end
      fail_count    <= mismatches;
      pending_count <= pending_words.size();
   end

endmodule

>>> tb/hybrid_logical_clock_core_tb.sv
// Stimulus, flow control and verdict for the hybrid logical clock core.
module hybrid_logical_clock_core_tb;
   import hlc_pkg::*;

   localparam int unsigned LOGICAL_BITS     = LOGICAL_BITS_DEF;
   localparam logic [STAMP_W-1:0] LOGIC_MASK = (64'd1 << LOGICAL_BITS) - 64'd1;
   localparam logic [STAMP_W-1:0] UNIT       = 64'd1 << LOGICAL_BITS;
   localparam logic [NS_W-1:0]    NS_MAX     = '1;
   localparam int unsigned IDLE_PCT         = 11;
   localparam int unsigned HOLD_OFF_CYCLES  = 60;
   localparam int unsigned HOLD_OFF_AFTER   = 150;
   localparam int unsigned STALL_LIMIT      = 2000;
   localparam int unsigned SKEW_PHASES      = 7;
   localparam int unsigned WORDS_PER_PHASE  = 76;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [CSR_W-1:0]   csr_wdata;
   int unsigned        fail_count;
   int unsigned        pending_count;

   logic               no_idle;
   logic [NS_W-1:0]    now_ns;
   logic [STAMP_W-1:0] skew_now;
   int unsigned        rsp_words;
   int unsigned        hold_left;
   logic               hold_done;
   int unsigned        quiet_cycles;

   hlc_req_if req_chan ();
   hlc_rsp_if rsp_chan ();

   hybrid_logical_clock_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   hlc_stamp_checker #(
      .LOGICAL_BITS (LOGICAL_BITS)
   ) stamp_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_kind        (req_chan.kind),
      .req_local_ns    (req_chan.local_ns),
      .req_msg_stamp   (req_chan.msg_stamp),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_stamp       (rsp_chan.stamp),
      .rsp_offset      (rsp_chan.offset),
      .rsp_sync_error  (rsp_chan.sync_error),
      .rsp_upper_bound (rsp_chan.upper_bound),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = ~clock;
   end

   // Physical part of a local time, in clock units
   function automatic logic [STAMP_W-1:0] phys_of(input logic [NS_W-1:0] ns);
      return {ns, {NS_SHIFT{1'b0}}} & ~LOGIC_MASK;
   endfunction

   // Offer one request word, idling now and then, and hold it until taken
   task automatic offer_word(input logic kind, input logic [NS_W-1:0] ns,
                             input logic [STAMP_W-1:0] msg);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.kind      <= kind;
      req_chan.local_ns  <= ns;
      req_chan.msg_stamp <= msg;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Mostly plausible traffic around the running time, plus some noise
   task automatic random_word();
      logic               kind;
      logic [NS_W-1:0]    ns;
      logic [STAMP_W-1:0] pt;
      logic [STAMP_W-1:0] msg;
      logic [STAMP_W-1:0] low;
      int unsigned        pick;
      now_ns = now_ns + NS_W'($urandom_range(0, 30000));
      ns = now_ns;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         ns = NS_W'({$urandom, $urandom});
      end else if (pick < 15) begin
         ns = now_ns - NS_W'($urandom_range(0, 200000));
      end
      pt   = phys_of(ns);
      low  = STAMP_W'($urandom) & LOGIC_MASK;
      kind = ($urandom_range(0, 1) == 0) ? KIND_LOCAL : KIND_RECV;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         msg = {$urandom, $urandom};
      end else if (pick < 30) begin
         // straddle the skew limit
         msg = pt + skew_now + (STAMP_W'($urandom_range(0, 2)) << LOGICAL_BITS) - UNIT;
         msg = (msg & ~LOGIC_MASK) | low;
      end else begin
         msg = pt + (STAMP_W'($urandom_range(0, 12)) << LOGICAL_BITS) - 6 * UNIT;
         msg = (msg & ~LOGIC_MASK) | low;
      end
      offer_word(kind, ns, msg);
   endtask

   // Drop valid and wait until every response word has come back
   task automatic drain_words(input int unsigned settle_cycles);
      req_chan.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (settle_cycles) @(negedge clock);
   endtask

   // Count response words
   always @(posedge clock) begin
      if (reset) begin
         rsp_words <= 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         rsp_words <= rsp_words + 1;
      end
   end

   // Drive ready: random stalls, one long hold-off to back up the core
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (!hold_done && rsp_words >= HOLD_OFF_AFTER) begin
         rsp_chan.ready <= 1'b0;
         hold_left = HOLD_OFF_CYCLES - 1;
         hold_done = 1'b1;
      end else begin
         rsp_chan.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Abort when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("hybrid_logical_clock_core test failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [CSR_W-1:0]   setting;
      logic [STAMP_W-1:0] pt;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.kind      = KIND_LOCAL;
      req_chan.local_ns  = '0;
      req_chan.msg_stamp = '0;
      no_idle            = 1'b0;
      skew_now           = OFFSET_RESET;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // local events: time zero, below one unit, a step, top of range, repeat
      offer_word(KIND_LOCAL, '0, '0);
      offer_word(KIND_LOCAL, NS_W'(1000), '1);
      offer_word(KIND_LOCAL, NS_W'(100000), '0);
      offer_word(KIND_LOCAL, NS_MAX, '0);
      offer_word(KIND_LOCAL, NS_MAX, '0);
      // merge at the top wraps the clock to zero
      offer_word(KIND_RECV, NS_MAX, '1);
      offer_word(KIND_LOCAL, NS_W'(5), '0);
      // messages far ahead raise a sync error
      offer_word(KIND_RECV, '0, 64'h8000_0000_0000_0000);
      offer_word(KIND_RECV, '0, '1);
      // reset skew limit: last whole unit inside, first unit past it
      offer_word(KIND_RECV, '0, (OFFSET_RESET & ~LOGIC_MASK) | 64'h1_2345);
      offer_word(KIND_RECV, '0, (OFFSET_RESET & ~LOGIC_MASK) + UNIT);
      // each arm of the merge around a base time
      offer_word(KIND_RECV, NS_W'(60'h100_0000_0000), 64'h0000_0000_0000_1234);
      offer_word(KIND_RECV, NS_W'(60'h100_0000_0000), 64'h0000_1000_0003_FFFF);
      offer_word(KIND_RECV, NS_W'(60'h100_0000_0000), 64'h0000_0000_0000_0000);
      offer_word(KIND_LOCAL, NS_W'(60'h100_0000_0000), '0);
      offer_word(KIND_RECV, NS_W'(60'h100_0010_0000), 64'h0000_1000_0080_0000);
      offer_word(KIND_RECV, NS_W'(60'h100_0010_0000), 64'h0000_1000_0200_0007);
      now_ns = NS_W'(60'h100_0010_0000);

      for (int ph = 0; ph < SKEW_PHASES; ph++) begin
         case (ph)
            0: begin
               setting = '0;
            end
            1: begin
               setting = '1;
            end
            2: begin
               setting = CSR_W'(1);
            end
            3: begin
               setting = CSR_W'(OFFSET_RESET);
            end
            4: begin
               setting = CSR_W'({$urandom, $urandom});
            end
            5: begin
               setting = CSR_W'(5) << LOGICAL_BITS;
            end
            default: begin
               setting = CSR_W'($urandom_range(1, 1 << 30));
            end
         endcase
         // write the skew limit only with the core idle
         drain_words(4);
         csr_we    <= 1'b1;
         csr_wdata <= setting;
         @(negedge clock);
         csr_we   <= 1'b0;
         skew_now = ({1'b0, setting} + LOGIC_MASK) & ~LOGIC_MASK;
         no_idle  = (ph == 3);
         // probe the new limit exactly, then one unit past it
         pt = phys_of(now_ns);
         offer_word(KIND_RECV, now_ns, pt + skew_now);
         offer_word(KIND_RECV, now_ns, pt + skew_now + UNIT + 64'h2A);
         repeat (WORDS_PER_PHASE) random_word();
      end

      drain_words(8);
      if (fail_count == 0) begin
         $display("hybrid_logical_clock_core test passed");
      end else begin
         $display("hybrid_logical_clock_core test failed");
      end
      $finish;
   end

endmodule
